### src/restriction_site_fragmenter_macros.svh
// Assertion macros used by the restriction site fragmenter top level.
`ifndef RESTRICTION_SITE_FRAGMENTER_MACROS_SVH
`define RESTRICTION_SITE_FRAGMENTER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RSF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define RSF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/rsf_pkg.sv
// Package with the types, constants and helper functions of the fragmenter.
package rsf_pkg;

   localparam int POSITION_BITS = 32;
   localparam int WIN_DEPTH = 9;
   localparam int FIELD_BITS = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef logic [POSITION_BITS-1:0] pos_type;
   typedef logic [FIELD_BITS-1:0] field_type;

   localparam pos_type POS_MAX = '1;
   localparam pos_type CUT_OFFSET = pos_type'(4);

   typedef enum logic {
      ENZ_XBAI,
      ENZ_XMNI
   } rsf_enzyme_type;

   localparam logic [7:0] LETTER_NONE = 8'h00;
   localparam logic [7:0] LETTER_A = 8'h41;
   localparam logic [7:0] LETTER_C = 8'h43;
   localparam logic [7:0] LETTER_G = 8'h47;
   localparam logic [7:0] LETTER_T = 8'h54;

   localparam logic [7:0] NEWEST_XBAI = LETTER_A;
   localparam logic [7:0] NEWEST_XMNI = LETTER_C;

   typedef struct packed {
      logic       xbai_care;
      logic [7:0] xbai_letter;
      logic       xmni_care;
      logic [7:0] xmni_letter;
   } rsf_cell_cfg_type;

   // Entry zero holds the base just before the newest one.
   localparam rsf_cell_cfg_type CELL_CFG [WIN_DEPTH] = '{
      '{1'b1, LETTER_G, 1'b1, LETTER_T},
      '{1'b1, LETTER_A, 1'b1, LETTER_T},
      '{1'b1, LETTER_T, 1'b0, LETTER_NONE},
      '{1'b1, LETTER_C, 1'b0, LETTER_NONE},
      '{1'b1, LETTER_T, 1'b0, LETTER_NONE},
      '{1'b0, LETTER_NONE, 1'b0, LETTER_NONE},
      '{1'b0, LETTER_NONE, 1'b1, LETTER_A},
      '{1'b0, LETTER_NONE, 1'b1, LETTER_A},
      '{1'b0, LETTER_NONE, 1'b1, LETTER_G}
   };

   typedef struct packed {
      field_type fragment_start;
      field_type fragment_length;
      field_type fragment_number;
      logic      final_fragment;
      field_type longest_fragment;
   } rsf_result_type;

   typedef struct packed {
      logic [1:0]     count;
      rsf_result_type first;
      rsf_result_type second;
   } rsf_push_type;

   function automatic pos_type sat_inc(pos_type v);
      return (v == POS_MAX) ? v : v + pos_type'(1);
   endfunction

   function automatic field_type to_field(pos_type v);
      logic [63:0] wide;
      wide = 64'(v);
      return wide[FIELD_BITS-1:0];
   endfunction

endpackage

### src/restriction_site_fragmenter.sv
// Top level of the restriction site fragmenter: window cells, tracker and queue.
//
// The block takes one base per cycle unless req_stall is high and answers it
// with zero, one or two results: a fragment closed by a recognition site, and
// on the final base the closing fragment, its number and the longest length.
// A row of nine window cells shifts the bases along and compares each against
// the selected site in the same cycle. The results of a base are written into
// a four-entry result queue at the edge that accepts the base, and rsp_valid is
// high in the cycle after that transfer. The input stalls only while the queue
// has fewer than two free entries; with the result side draining one result
// per cycle the sustained rate is one base per cycle. There is no clearing pass
// after reset. The user must write the enzyme register only while no transfer
// is under way; the block itself does not enforce this.
`include "restriction_site_fragmenter_macros.svh"

module restriction_site_fragmenter (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic                    csr_write_data,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_base_char,
   input  logic                    req_end_of_sequence,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsf_pkg::field_type      rsp_fragment_start,
   output rsf_pkg::field_type      rsp_fragment_length,
   output rsf_pkg::field_type      rsp_fragment_number,
   output logic                    rsp_final_fragment,
   output rsf_pkg::field_type      rsp_longest_fragment
);
   import rsf_pkg::*;

   rsf_enzyme_type enzyme_ff;
   logic           accept;
   logic           room;
   logic [7:0]     chain [WIN_DEPTH];
   logic [WIN_DEPTH-1:0] cell_match;
   rsf_push_type   push;
   rsf_result_type head;

   always_ff @(posedge clock) begin
      if (reset) begin
         enzyme_ff <= ENZ_XBAI;
      end else if (csr_write_enable) begin
         enzyme_ff <= rsf_enzyme_type'(csr_write_data);
      end
   end

   assign req_stall = !room;
   assign accept = req_valid && !req_stall;

   for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
      rsf_window_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift      (accept),
         .clear      (accept && req_end_of_sequence),
         .enzyme     (enzyme_ff),
         .cfg        (CELL_CFG[i]),
         .shift_byte ((i == 0) ? req_base_char : chain[(i == 0) ? 0 : i - 1]),
         .byte_out   (chain[i]),
         .match      (cell_match[i])
      );
   end

   rsf_tracker u_tracker (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .base_char       (req_base_char),
      .end_of_sequence (req_end_of_sequence),
      .enzyme          (enzyme_ff),
      .window_match    ((&cell_match) && (chain[WIN_DEPTH-1] == chain[WIN_DEPTH-1])),
      .push            (push)
   );

   rsf_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_fragment_start = head.fragment_start;
   assign rsp_fragment_length = head.fragment_length;
   assign rsp_fragment_number = head.fragment_number;
   assign rsp_final_fragment = head.final_fragment;
   assign rsp_longest_fragment = head.longest_fragment;

   `RSF_ASSERT_NEXT(a_push_shows, clock, reset, push.count != 2'd0, rsp_valid, "queued result not shown")
   `RSF_ASSERT_SAME(a_stall_needs_data, clock, reset, !rsp_valid, !req_stall, "input stalled with empty queue")
   `RSF_ASSERT_SAME(a_pair_order, clock, reset, push.count == 2'd2, !push.first.final_fragment && push.second.final_fragment, "two results out of order")
   `RSF_ASSERT_SAME(a_longest_final_only, clock, reset, rsp_valid && !rsp_final_fragment, rsp_longest_fragment == '0, "longest length on a site fragment")

endmodule

### src/rsf_window_cell.sv
// One cell of the base window: holds a byte, shifts it on, and matches it.
module rsf_window_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      shift,
   input  logic                      clear,
   input  rsf_pkg::rsf_enzyme_type   enzyme,
   input  rsf_pkg::rsf_cell_cfg_type cfg,
   input  logic [7:0]                shift_byte,
   output logic [7:0]                byte_out,
   output logic                      match
);
   import rsf_pkg::*;

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   always_comb begin
      byte_in = byte_ff;
      if (clear) begin
         byte_in = LETTER_NONE;
      end else if (shift) begin
         byte_in = shift_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= LETTER_NONE;
      end else begin
         byte_ff <= byte_in;
      end
   end

   always_comb begin
      case (enzyme)
         ENZ_XBAI: match = !cfg.xbai_care || (byte_ff == cfg.xbai_letter);
         ENZ_XMNI: match = !cfg.xmni_care || (byte_ff == cfg.xmni_letter);
         default:  match = 1'b0;
      endcase
   end

   assign byte_out = byte_ff;

endmodule

### src/rsf_tracker.sv
// Position, cut and fragment bookkeeping that forms the results of each base.
module rsf_tracker (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              base_char,
   input  logic                    end_of_sequence,
   input  rsf_pkg::rsf_enzyme_type enzyme,
   input  logic                    window_match,
   output rsf_pkg::rsf_push_type   push
);
   import rsf_pkg::*;

   pos_type position_ff, position_in;
   pos_type prev_cut_ff, prev_cut_in;
   pos_type frag_count_ff, frag_count_in;
   pos_type longest_ff, longest_in;

   logic           newest_match;
   logic           site;
   pos_type        cut;
   pos_type        site_len;
   pos_type        prev_after_site;
   pos_type        count_after_site;
   pos_type        longest_after_site;
   pos_type        total;
   pos_type        final_len;
   pos_type        longest_final;
   rsf_result_type site_res;
   rsf_result_type final_res;

   always_comb begin
      case (enzyme)
         ENZ_XBAI: newest_match = (base_char == NEWEST_XBAI);
         ENZ_XMNI: newest_match = (base_char == NEWEST_XMNI);
         default:  newest_match = 1'b0;
      endcase
      site = newest_match && window_match;

      cut = (position_ff >= CUT_OFFSET) ? position_ff - CUT_OFFSET : '0;
      site_len = (cut > prev_cut_ff) ? cut - prev_cut_ff : '0;
      prev_after_site = site ? cut : prev_cut_ff;
      count_after_site = site ? sat_inc(frag_count_ff) : frag_count_ff;
      longest_after_site = (site && site_len > longest_ff) ? site_len : longest_ff;

      total = sat_inc(position_ff);
      final_len = (total > prev_after_site) ? total - prev_after_site : '0;
      longest_final = (final_len > longest_after_site) ? final_len : longest_after_site;

      site_res.fragment_start = to_field(prev_cut_ff);
      site_res.fragment_length = to_field(site_len);
      site_res.fragment_number = to_field(frag_count_ff);
      site_res.final_fragment = 1'b0;
      site_res.longest_fragment = '0;

      final_res.fragment_start = to_field(prev_after_site);
      final_res.fragment_length = to_field(final_len);
      final_res.fragment_number = to_field(count_after_site);
      final_res.final_fragment = 1'b1;
      final_res.longest_fragment = to_field(longest_final);

      push.first = site ? site_res : final_res;
      push.second = final_res;
      if (!accept) begin
         push.count = 2'd0;
      end else begin
         push.count = 2'(site) + 2'(end_of_sequence);
      end

      position_in = position_ff;
      prev_cut_in = prev_cut_ff;
      frag_count_in = frag_count_ff;
      longest_in = longest_ff;
      if (accept) begin
         if (end_of_sequence) begin
            position_in = '0;
            prev_cut_in = '0;
            frag_count_in = '0;
            longest_in = '0;
         end else begin
            position_in = total;
            prev_cut_in = prev_after_site;
            frag_count_in = count_after_site;
            longest_in = longest_after_site;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         prev_cut_ff <= '0;
         frag_count_ff <= '0;
         longest_ff <= '0;
      end else begin
         position_ff <= position_in;
         prev_cut_ff <= prev_cut_in;
         frag_count_ff <= frag_count_in;
         longest_ff <= longest_in;
      end
   end

endmodule

### src/rsf_result_queue.sv
// Small result queue that takes up to two results a cycle and hands out one unless stalled.
module rsf_result_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  rsf_pkg::rsf_push_type push,
   output logic                  room,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsf_pkg::rsf_result_type head
);
   import rsf_pkg::*;

   rsf_result_type entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   rd_ff, rd_in;
   logic [QUEUE_PTR_BITS-1:0]   wr_ff, wr_in;
   logic [QUEUE_COUNT_BITS-1:0] count_ff, count_in;
   logic [QUEUE_PTR_BITS-1:0]   wr_next;
   logic                        pop;

   assign pop = (count_ff != '0) && !rsp_stall;
   assign wr_next = wr_ff + QUEUE_PTR_BITS'(1);

   always_comb begin
      rd_in = pop ? rd_ff + QUEUE_PTR_BITS'(1) : rd_ff;
      wr_in = wr_ff + QUEUE_PTR_BITS'(push.count);
      count_in = count_ff + QUEUE_COUNT_BITS'(push.count) - QUEUE_COUNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0;
         wr_ff <= '0;
         count_ff <= '0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (push.count != 2'd0 && wr_ff == QUEUE_PTR_BITS'(i)) begin
            entry_ff[i] <= push.first;
         end else if (push.count == 2'd2 && wr_next == QUEUE_PTR_BITS'(i)) begin
            entry_ff[i] <= push.second;
         end
      end
   end

   assign room = (count_ff <= QUEUE_COUNT_BITS'(QUEUE_DEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign head = entry_ff[rd_ff];

endmodule

### dv/restriction_site_fragmenter_test.sv
// Self-checking testbench for the restriction site fragmenter with a fragment scoreboard.
`timescale 1ns / 1ps

module restriction_site_fragmenter_test;
   import rsf_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int RANDOM_BASES = 1850;
   localparam int PHASE_BASES = 200;
   localparam int HOLD_CYCLES = 120;
   localparam int SETTLE_CYCLES = 20;

   class fragment_scoreboard;
      rsf_enzyme_type enzyme;
      logic [7:0] recent [WIN_DEPTH];
      pos_type next_pos;
      pos_type last_cut;
      pos_type frag_count;
      pos_type longest;
      rsf_result_type pending_fragments [$];
      int fragments_checked;
      int sequences_closed;
      int mismatches;

      function new();
         enzyme = ENZ_XBAI;
         fragments_checked = 0;
         sequences_closed = 0;
         mismatches = 0;
         clear_digest();
      endfunction

      function void clear_digest();
         for (int i = 0; i < WIN_DEPTH; i++) recent[i] = LETTER_NONE;
         next_pos = '0;
         last_cut = '0;
         frag_count = '0;
         longest = '0;
      endfunction

      function pos_type step_up(pos_type v);
         return (v == '1) ? v : v + pos_type'(1);
      endfunction

      function bit site_found(logic [7:0] b);
         if (enzyme == ENZ_XBAI) begin
            return recent[4] == LETTER_T && recent[3] == LETTER_C && recent[2] == LETTER_T &&
                   recent[1] == LETTER_A && recent[0] == LETTER_G && b == LETTER_A;
         end
         return recent[8] == LETTER_G && recent[7] == LETTER_A && recent[6] == LETTER_A &&
                recent[1] == LETTER_T && recent[0] == LETTER_T && b == LETTER_C;
      endfunction

      function void close_at(pos_type edge_pos, bit closing);
         rsf_result_type frag;
         pos_type span;
         span = (edge_pos > last_cut) ? edge_pos - last_cut : '0;
         if (span > longest) longest = span;
         frag.fragment_start = last_cut;
         frag.fragment_length = span;
         frag.fragment_number = frag_count;
         frag.final_fragment = closing;
         frag.longest_fragment = closing ? longest : '0;
         pending_fragments.push_back(frag);
      endfunction

      function void note_base(logic [7:0] b, logic last);
         pos_type cut;
         if (site_found(b)) begin
            cut = (next_pos >= pos_type'(4)) ? next_pos - pos_type'(4) : '0;
            close_at(cut, 1'b0);
            last_cut = cut;
            frag_count = step_up(frag_count);
         end
         if (last) begin
            close_at(step_up(next_pos), 1'b1);
            clear_digest();
         end else begin
            for (int i = WIN_DEPTH - 1; i > 0; i--) recent[i] = recent[i-1];
            recent[0] = b;
            next_pos = step_up(next_pos);
         end
      endfunction

      function void compare_field(string name, field_type want, field_type got);
         if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void check_fragment(field_type start, field_type length, field_type number,
                                   logic closing, field_type longest_seen);
         rsf_result_type want;
         if (pending_fragments.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected fragment start %0d length %0d number %0d final %0b",
                     $time, start, length, number, closing);
            return;
         end
         want = pending_fragments.pop_front();
         fragments_checked++;
         if (closing === 1'b1) sequences_closed++;
         compare_field("fragment_start", want.fragment_start, start);
         compare_field("fragment_length", want.fragment_length, length);
         compare_field("fragment_number", want.fragment_number, number);
         compare_field("final_fragment", field_type'(want.final_fragment), field_type'(closing));
         compare_field("longest_fragment", want.longest_fragment, longest_seen);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic csr_write_data = 1'b0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_base_char = 8'h00;
   logic req_end_of_sequence = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   field_type rsp_fragment_start;
   field_type rsp_fragment_length;
   field_type rsp_fragment_number;
   logic rsp_final_fragment;
   field_type rsp_longest_fragment;

   fragment_scoreboard digest;
   int bases_sent = 0;
   int cycle_count = 0;
   int stall_left = 0;
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;
   bit hold_off = 1'b0;

   restriction_site_fragmenter uut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_base_char(req_base_char),
      .req_end_of_sequence(req_end_of_sequence),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_fragment_start(rsp_fragment_start),
      .rsp_fragment_length(rsp_fragment_length),
      .rsp_fragment_number(rsp_fragment_number),
      .rsp_final_fragment(rsp_final_fragment),
      .rsp_longest_fragment(rsp_longest_fragment)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Run stopped at the cycle limit with %0d fragments still due.",
                  digest.pending_fragments.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic int pick_pause(bit calm);
      int r;
      r = $urandom_range(99);
      if (calm || r < 70) return 0;
      if (r < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   function automatic logic [7:0] pick_letter();
      case ($urandom_range(3))
         0: return LETTER_A;
         1: return LETTER_C;
         2: return LETTER_G;
         default: return LETTER_T;
      endcase
   endfunction

   always @(negedge clock) begin
      if (stall_left > 0) stall_left = stall_left - 1;
      else stall_left = pick_pause(rsp_calm);
      rsp_stall <= hold_off || (stall_left > 0);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         digest.check_fragment(rsp_fragment_start, rsp_fragment_length, rsp_fragment_number,
                               rsp_final_fragment, rsp_longest_fragment);
      end
   end

   // The receiver holds off twice while the sender keeps offering bases.
   initial begin
      int threshold;
      threshold = 600;
      repeat (2) begin
         while (bases_sent < threshold) @(posedge clock);
         hold_off = 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_off = 1'b0;
         threshold = threshold + 800;
      end
   end

   task automatic send_base(logic [7:0] b, logic last, int gap);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_base_char <= b;
      req_end_of_sequence <= last;
      do @(posedge clock); while (req_stall);
      digest.note_base(b, last);
      bases_sent++;
   endtask

   task automatic send_run(logic [7:0] run [$]);
      for (int i = 0; i < run.size(); i++) begin
         send_base(run[i], i == run.size() - 1, pick_pause(req_calm));
      end
   endtask

   task automatic write_enzyme(rsf_enzyme_type e);
      @(negedge clock);
      req_valid <= 1'b0;
      while (digest.pending_fragments.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= e;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      digest.enzyme = e;
   endtask

   task automatic plant_site(ref logic [7:0] bases [$], input rsf_enzyme_type e,
                             input bit at_end);
      logic [7:0] site [$];
      int at;
      int k;
      if (e == ENZ_XBAI) begin
         site = '{LETTER_T, LETTER_C, LETTER_T, LETTER_A, LETTER_G, LETTER_A};
      end else begin
         site = '{LETTER_G, LETTER_A, LETTER_A, 8'h00, 8'h00, 8'h00, 8'h00,
                  LETTER_T, LETTER_T, LETTER_C};
         for (k = 3; k < 7; k++) begin
            site[k] = ($urandom_range(1) == 0) ? pick_letter() : 8'($urandom_range(255));
         end
      end
      if (site.size() > bases.size()) return;
      if ($urandom_range(4) == 0) begin
         k = $urandom_range(site.size() - 1);
         site[k] = site[k] ^ 8'h20;
      end
      at = at_end ? bases.size() - site.size() : $urandom_range(bases.size() - site.size());
      for (k = 0; k < site.size(); k++) bases[at + k] = site[k];
   endtask

   task automatic send_random_sequence();
      logic [7:0] bases [$];
      int len;
      int r;
      int i;
      bit noisy;
      rsf_enzyme_type e;
      r = $urandom_range(99);
      if (r < 80) len = $urandom_range(30, 1);
      else if (r < 97) len = $urandom_range(120, 31);
      else len = $urandom_range(400, 121);
      noisy = ($urandom_range(99) < 8);
      for (i = 0; i < len; i++) begin
         if (noisy || $urandom_range(99) < 8) bases.push_back(8'($urandom_range(255)));
         else bases.push_back(pick_letter());
      end
      if (!noisy) begin
         repeat ($urandom_range(3)) begin
            e = ($urandom_range(99) < 85) ? digest.enzyme
                : (digest.enzyme == ENZ_XBAI ? ENZ_XMNI : ENZ_XBAI);
            plant_site(bases, e, $urandom_range(3) == 0);
         end
      end
      send_run(bases);
   endtask

   initial begin
      logic [7:0] run [$];
      int phase;
      int phase_end;
      int random_goal;
      digest = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run = '{LETTER_T, LETTER_C, LETTER_T, LETTER_A, LETTER_G, LETTER_A, LETTER_C,
              LETTER_T, LETTER_C, LETTER_T, LETTER_A, LETTER_G, LETTER_A};
      send_run(run);
      run = '{8'hFF};
      send_run(run);
      run = '{8'h00, 8'h74};
      send_run(run);
      write_enzyme(ENZ_XMNI);
      run = '{LETTER_G, LETTER_A, LETTER_A, 8'h00, 8'hFF, 8'h6E, LETTER_A,
              LETTER_T, LETTER_T, LETTER_C};
      send_run(run);

      random_goal = bases_sent + RANDOM_BASES;
      phase = 0;
      while (bases_sent < random_goal) begin
         write_enzyme(phase[0] ? ENZ_XMNI : ENZ_XBAI);
         req_calm = (phase % 3 == 1);
         rsp_calm = (phase % 3 == 2) || (phase % 5 == 4);
         phase_end = bases_sent + PHASE_BASES;
         while (bases_sent < phase_end && bases_sent < random_goal) send_random_sequence();
         phase++;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (digest.pending_fragments.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Digested %0d bases over %0d random phases with both enzymes.", bases_sent, phase);
      $display("Checked %0d fragments, %0d of them closing a sequence; %0d mismatches.",
               digest.fragments_checked, digest.sequences_closed, digest.mismatches);
      if (digest.mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
